// File: design/lccf_pkg.sv
package lccf_pkg;

    localparam int NUM_LEVELS = 6;
    localparam int LEVEL_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int SEL_W      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_COLOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_COLOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL4_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL5_COLOR = 3'd5;

    localparam logic [SEL_W-1:0] TOP_LEVEL = 3'd5;

    localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    localparam color_t LEVEL_COLOR_RESET [NUM_LEVELS] = '{
        24'h01C8FF, 24'h3CFF01, 24'hE67801, 24'hFF2801, 24'hFF01AA, 24'hFF0101
    };

endpackage

// File: design/level_color_crossfade_unit.sv
// Level colour crossfade. Each item on the s_ channel is one tick carrying the
// current quality level. When idle and the level differs from the last one faded
// to (or none has been seen since reset), the level is saturated to 0..5, its
// colour register is latched as the target, and a fade of FADE_STEPS ticks from
// the previous colour begins; every tick of the fade, the starting one included,
// yields one blended colour on the m_ channel, with m_fade_last high on the final
// step. Levels that arrive during a fade are dropped, and idle ticks with an
// unchanged level yield nothing. One item is taken every cycle while the pipeline
// is not held; each result passes through the select, weighted-sum and
// reciprocal-divide stages, and the whole pipeline holds while a result waits on
// m_valid with m_ready low.
// Colour registers are written through cfg_wen/cfg_index/cfg_data; a write does
// not disturb a fade already in progress.
module level_color_crossfade_unit #(
    parameter int FADE_STEPS = 255
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wen,
    input  logic [lccf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lccf_pkg::COLOR_W-1:0]    cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lccf_pkg::LEVEL_W-1:0]    s_level,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lccf_pkg::CHAN_W-1:0]     m_red,
    output logic [lccf_pkg::CHAN_W-1:0]     m_green,
    output logic [lccf_pkg::CHAN_W-1:0]     m_blue,
    output logic                            m_fade_last
);
    import lccf_pkg::*;

    localparam int STEP_W  = (FADE_STEPS > 2) ? $clog2(FADE_STEPS) : 1;
    localparam int WGT_W   = $clog2(FADE_STEPS + 1);
    localparam int SUM_W   = CHAN_W + WGT_W;
    localparam int SHIFT   = SUM_W + $clog2(FADE_STEPS);
    localparam int RECIP_W = SUM_W + 2;
    localparam longint RECIP_VAL =
        ((longint'(1) << SHIFT) + longint'(FADE_STEPS) - 1) / longint'(FADE_STEPS);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_VAL);
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(FADE_STEPS - 1);
    localparam logic [WGT_W-1:0]   STEPS_W   = WGT_W'(FADE_STEPS);
    localparam int PROD_W = SUM_W + RECIP_W;

    // Colour registers
    color_t color_reg [NUM_LEVELS];

    // Fade state
    color_t              from_color_reg;
    color_t              to_color_reg;
    logic [LEVEL_W-1:0]  last_level_reg;
    logic                level_seen_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                fading_reg;

    // Pipeline stages
    logic                advance;
    logic                sel_valid_reg;
    rgb_t                sel_from_reg;
    rgb_t                sel_to_reg;
    logic [STEP_W-1:0]   sel_step_reg;
    logic                sel_last_reg;

    logic                sum_valid_reg;
    logic [SUM_W-1:0]    sum_reg [3];
    logic                sum_last_reg;

    logic                out_valid_reg;
    rgb_t                out_rgb_reg;
    logic                out_last_reg;

    logic                accept;
    logic                start;
    logic                emit;
    logic [SEL_W-1:0]    level_sel;
    color_t              target;
    logic [STEP_W-1:0]   cur_step;
    logic                cur_last;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // Decide whether this tick starts a fade or continues one
    always_comb begin
        level_sel = (s_level > LEVEL_W'(TOP_LEVEL)) ? TOP_LEVEL : s_level[SEL_W-1:0];
        start     = !fading_reg && !(level_seen_reg && (s_level == last_level_reg));
        emit      = fading_reg || start;
        target    = start ? color_reg[level_sel] : to_color_reg;
        cur_step  = start ? '0 : step_reg;
        cur_last  = (cur_step == LAST_STEP);
    end

    // Write colour registers; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                color_reg[k] <= LEVEL_COLOR_RESET[k];
            end
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_LEVEL0_COLOR: color_reg[0] <= cfg_data;
                REG_LEVEL1_COLOR: color_reg[1] <= cfg_data;
                REG_LEVEL2_COLOR: color_reg[2] <= cfg_data;
                REG_LEVEL3_COLOR: color_reg[3] <= cfg_data;
                REG_LEVEL4_COLOR: color_reg[4] <= cfg_data;
                REG_LEVEL5_COLOR: color_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the fade state on each accepted item that yields a colour
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            from_color_reg <= WHITE;
            to_color_reg   <= '0;
            last_level_reg <= '0;
            level_seen_reg <= 1'b0;
            step_reg       <= '0;
            fading_reg     <= 1'b0;
        end else if (accept && emit) begin
            if (start) begin
                to_color_reg   <= target;
                last_level_reg <= s_level;
                level_seen_reg <= 1'b1;
            end
            if (cur_last) begin
                from_color_reg <= target;
                step_reg       <= '0;
                fading_reg     <= 1'b0;
            end else begin
                step_reg   <= cur_step + STEP_W'(1);
                fading_reg <= 1'b1;
            end
        end
    end

    // Select stage: latch endpoints and step of this tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (advance) begin
            sel_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sel_from_reg <= rgb_t'(from_color_reg);
            sel_to_reg   <= rgb_t'(target);
            sel_step_reg <= cur_step;
            sel_last_reg <= cur_last;
        end
    end

    // Weighted sum stage: old*(STEPS-i) + new*i per channel
    logic [WGT_W-1:0]  wgt_new;
    logic [WGT_W-1:0]  wgt_old;
    logic [CHAN_W-1:0] chan_from [3];
    logic [CHAN_W-1:0] chan_to   [3];
    logic [SUM_W-1:0]  sum_next  [3];

    always_comb begin
        wgt_new      = WGT_W'(sel_step_reg);
        wgt_old      = STEPS_W - wgt_new;
        chan_from[0] = sel_from_reg.red;
        chan_from[1] = sel_from_reg.green;
        chan_from[2] = sel_from_reg.blue;
        chan_to[0]   = sel_to_reg.red;
        chan_to[1]   = sel_to_reg.green;
        chan_to[2]   = sel_to_reg.blue;
        for (int c = 0; c < 3; c++) begin
            sum_next[c] = SUM_W'(chan_from[c]) * SUM_W'(wgt_old)
                        + SUM_W'(chan_to[c]) * SUM_W'(wgt_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (advance) begin
            sum_valid_reg <= sel_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= sum_next[c];
            end
            sum_last_reg <= sel_last_reg;
        end
    end

    // Divide stage: exact for every sum by a rounded-up reciprocal
    logic [PROD_W-1:0] prod      [3];
    logic [CHAN_W-1:0] quot_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c]      = PROD_W'(sum_reg[c]) * PROD_W'(RECIP);
            quot_next[c] = prod[c][SHIFT +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rgb_reg.red   <= quot_next[0];
            out_rgb_reg.green <= quot_next[1];
            out_rgb_reg.blue  <= quot_next[2];
            out_last_reg      <= sum_last_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_red       = out_rgb_reg.red;
    assign m_green     = out_rgb_reg.green;
    assign m_blue      = out_rgb_reg.blue;
    assign m_fade_last = out_last_reg;

`ifndef SYNTH
    // Idle state always rests at step zero
    a_idle_step_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !fading_reg |-> (step_reg == '0))
        else $error("step index not zero while idle");

    // No fade before any level has been seen
    a_fade_needs_level: assert property (@(posedge aclk) disable iff (!aresetn)
        !level_seen_reg |-> !fading_reg)
        else $error("fade running with no level seen");

    // Final step returns the block to idle with the target as the new origin
    a_last_ends_fade: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && emit && cur_last) |=> (!fading_reg && (from_color_reg == $past(target))))
        else $error("final step did not end the fade");

    // A starting tick records its raw level and enters the fade
    a_start_records: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && start) |=> (fading_reg && level_seen_reg
                               && (last_level_reg == $past(s_level))))
        else $error("fade start not recorded");

    // Unchanged level while idle leaves the fade state alone
    a_idle_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !emit) |=> (!fading_reg && $stable(from_color_reg)))
        else $error("idle tick changed state");
`endif

endmodule
